[sv/sfcc_pkg.sv]
// sfcc_pkg: payload types, frame constants and the CRC-16 constants
// shared by sfcc_crc_step, the sensor frame CRC checker and its
// checker module. No dependencies.
package sfcc_pkg;

	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [7:0]  FUNC_CODE = 8'h03;
	localparam logic [7:0]  REG_COUNT = 8'h04;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_HDR = 2'd1;
	localparam logic [1:0] ST_BAD_CRC = 2'd2;

	localparam logic [2:0] IDX_FUNC   = 3'd0;
	localparam logic [2:0] IDX_COUNT  = 3'd1;
	localparam logic [2:0] IDX_HUM_HI = 3'd2;
	localparam logic [2:0] IDX_HUM_LO = 3'd3;
	localparam logic [2:0] IDX_TMP_HI = 3'd4;
	localparam logic [2:0] IDX_TMP_LO = 3'd5;
	localparam logic [2:0] IDX_CRC_LO = 3'd6;
	localparam logic [2:0] IDX_CRC_HI = 3'd7;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} rx_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [15:0] temperature_tenths;
		logic [15:0]        humidity_tenths;
	} res_t;

endpackage

[sv/sfcc_crc_step.sv]
// sfcc_crc_step: one-byte update of the reflected CRC-16 (poly 0xA001).
// Depends on sfcc_pkg.
module sfcc_crc_step (
	input  logic [15:0] crc,
	input  logic [7:0]  data,
	output logic [15:0] crc_next
);

	always_comb begin
		logic [15:0] c;
		c = crc ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ sfcc_pkg::CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_next = c;
	end

endmodule

[sv/sensor_frame_crc_checker.sv]
// sensor_frame_crc_checker: checks an 8-byte sensor response frame (header,
// humidity, sign-magnitude temperature, CRC-16 low byte first).
// Depends on sfcc_pkg and sfcc_crc_step.
//
//   channel | payload       | handshake          | per transfer
//   rx      | sfcc_pkg::rx_t  | rx_valid/rx_ready  | one frame byte
//   res     | sfcc_pkg::res_t | res_valid/res_ready| one result per frame
//
// One byte per cycle unless rx is stalled; a frame's result is registered and
// shows in the cycle after its eighth byte is taken. CRC update is an 8-step
// unrolled shift. Reset sets the frame position to 0, the CRC to 0xFFFF
// and clears result valid. A held result stalls rx only at the eighth byte.
module sensor_frame_crc_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rx_valid,
	output logic           rx_ready,
	input  sfcc_pkg::rx_t  rx_data,
	output logic           res_valid,
	input  logic           res_ready,
	output sfcc_pkg::res_t res_data
);

	logic [2:0]  byte_index_q;
	logic [15:0] crc_q;
	logic        header_good_q;
	logic [15:0] hum_q;
	logic [15:0] tmp_q;
	logic [7:0]  crc_lo_q;
	logic        res_valid_q;
	sfcc_pkg::res_t res_q;

	logic        rx_fire;
	logic [2:0]  idx;
	logic [15:0] crc_cur;
	logic        hg_cur;
	logic [15:0] crc_upd;
	logic        done;
	sfcc_pkg::res_t res_d;

	assign rx_ready = !res_valid_q || res_ready || (byte_index_q != sfcc_pkg::IDX_CRC_HI);
	assign rx_fire  = rx_valid && rx_ready;

	assign idx     = rx_data.frame_start ? sfcc_pkg::IDX_FUNC : byte_index_q;
	assign crc_cur = rx_data.frame_start ? sfcc_pkg::CRC_INIT : crc_q;
	assign hg_cur  = rx_data.frame_start ? 1'b1 : header_good_q;
	assign done    = (idx == sfcc_pkg::IDX_CRC_HI);

	sfcc_crc_step u_crc (
		.crc      (crc_cur),
		.data     (rx_data.rx_byte),
		.crc_next (crc_upd)
	);

	always_comb begin
		logic [14:0] mag;
		mag   = tmp_q[14:0];
		res_d = '0;
		if (!hg_cur) begin
			res_d.status = sfcc_pkg::ST_BAD_HDR;
		end else if ({rx_data.rx_byte, crc_lo_q} != crc_cur) begin
			res_d.status = sfcc_pkg::ST_BAD_CRC;
		end else begin
			res_d.status = sfcc_pkg::ST_OK;
			res_d.temperature_tenths = tmp_q[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
			res_d.humidity_tenths = hum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q  <= sfcc_pkg::IDX_FUNC;
			crc_q         <= sfcc_pkg::CRC_INIT;
			header_good_q <= 1'b1;
		end else if (rx_fire) begin
			if (done) begin
				byte_index_q  <= sfcc_pkg::IDX_FUNC;
				crc_q         <= sfcc_pkg::CRC_INIT;
				header_good_q <= 1'b1;
			end else begin
				byte_index_q <= idx + 3'd1;
				crc_q        <= (idx < sfcc_pkg::IDX_CRC_LO) ? crc_upd : crc_cur;
				if ((idx == sfcc_pkg::IDX_FUNC && rx_data.rx_byte != sfcc_pkg::FUNC_CODE) ||
				    (idx == sfcc_pkg::IDX_COUNT && rx_data.rx_byte != sfcc_pkg::REG_COUNT)) begin
					header_good_q <= 1'b0;
				end else begin
					header_good_q <= hg_cur;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_fire) begin
			case (idx)
				sfcc_pkg::IDX_HUM_HI: hum_q[15:8] <= rx_data.rx_byte;
				sfcc_pkg::IDX_HUM_LO: hum_q[7:0]  <= rx_data.rx_byte;
				sfcc_pkg::IDX_TMP_HI: tmp_q[15:8] <= rx_data.rx_byte;
				sfcc_pkg::IDX_TMP_LO: tmp_q[7:0]  <= rx_data.rx_byte;
				sfcc_pkg::IDX_CRC_LO: crc_lo_q    <= rx_data.rx_byte;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rx_fire && done) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_fire && done) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

[sv/sfcc_checker.sv]
// sfcc_checker: port-level assertions for sensor_frame_crc_checker.
// Depends on sfcc_pkg; bound to the top level below.
module sfcc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           rx_valid,
	input logic           rx_ready,
	input sfcc_pkg::rx_t  rx_data,
	input logic           res_valid,
	input logic           res_ready,
	input sfcc_pkg::res_t res_data
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result dropped or changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.status == sfcc_pkg::ST_OK ||
		               res_data.status == sfcc_pkg::ST_BAD_HDR ||
		               res_data.status == sfcc_pkg::ST_BAD_CRC))
		else $error("illegal status");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.status != sfcc_pkg::ST_OK |->
		res_data.temperature_tenths == 16'sd0 && res_data.humidity_tenths == 16'd0)
		else $error("error result carries data");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.temperature_tenths != 16'sh8000)
		else $error("temperature out of range");

	a_no_early_res: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid && !(rx_valid && rx_ready) |=> !res_valid)
		else $error("result without a transfer");

endmodule

bind sensor_frame_crc_checker sfcc_checker u_sfcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rx_valid  (rx_valid),
	.rx_ready  (rx_ready),
	.rx_data   (rx_data),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res_data  (res_data)
);
